// ----- hdl/lfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared types, codes and constants for the line-follow steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

  // frames after which a turn is abandoned
  localparam int unsigned TURN_LIMIT = 200;
  // steering clamp, Q8
  localparam int signed STEER_LIMIT_Q8 = 60 * 256;
  // floor(y/15) = (y*DIV15_RECIP) >> 16 for y < 2048
  localparam logic [12:0] DIV15_RECIP = 13'd4370;

  // configuration register indexes
  localparam logic [2:0] CFG_SPEED_FAST = 3'd0;
  localparam logic [2:0] CFG_SPEED_SLOW = 3'd1;
  localparam logic [2:0] CFG_SPEED_MIN  = 3'd2;
  localparam logic [2:0] CFG_GAIN_P     = 3'd3;
  localparam logic [2:0] CFG_GAIN_D     = 3'd4;

  // track status codes
  localparam logic [3:0] ST_GO     = 4'd0;
  localparam logic [3:0] ST_RIGHT1 = 4'd1;
  localparam logic [3:0] ST_RIGHT2 = 4'd2;
  localparam logic [3:0] ST_RIGHT3 = 4'd3;
  localparam logic [3:0] ST_LEFT1  = 4'd4;
  localparam logic [3:0] ST_LEFT2  = 4'd5;
  localparam logic [3:0] ST_LEFT3  = 4'd6;
  localparam logic [3:0] ST_LOST   = 4'd7;
  localparam logic [3:0] ST_CROSS  = 4'd8;
  localparam logic [3:0] ST_TURN   = 4'd9;
  localparam logic [3:0] ST_SEARCH = 4'd10;

  // turn mode codes as reported
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_LEFT   = 2'd1;
  localparam logic [1:0] MODE_RIGHT  = 2'd2;

  // how the wheels are driven for a frame
  typedef enum logic [1:0] {
    DRIVE_PD     = 2'd0,
    DRIVE_SEARCH = 2'd1,
    DRIVE_LEFT   = 2'd2,
    DRIVE_RIGHT  = 2'd3
  } drive_t;

  typedef struct packed {
    logic [6:0]  speed_fast;
    logic [6:0]  speed_slow;
    logic [6:0]  speed_min;
    logic [11:0] gain_p;
    logic [11:0] gain_d;
  } cfg_t;

  // fields passed straight to the result
  typedef struct packed {
    logic [1:0] turn_mode;
    logic [7:0] turn_count;
    logic       beeper_on;
    logic [3:0] track_status;
  } tail_t;

  // decoded frame handed to the steering datapath
  typedef struct packed {
    drive_t            drive;
    logic signed [4:0] err;
    logic signed [5:0] diff;
    logic [3:0]        mag;
    tail_t             tail;
  } trk_t;

  // weight of one side's three outer sensors, outermost in the top bit
  function automatic logic [3:0] side_weight(input logic [2:0] idx);
    logic [3:0] w;
    case (idx)
      3'd0:    w = 4'd0;
      3'd1:    w = 4'd1;
      3'd2:    w = 4'd4;
      3'd3:    w = 4'd6;
      3'd4:    w = 4'd6;
      3'd5:    w = 4'd7;
      3'd6:    w = 4'd10;
      3'd7:    w = 4'd12;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lfsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lfsc_cfg_regs
// Configuration register bank with write-only access.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_cfg_regs import lfsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t regs;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.speed_fast <= 7'd45;
      regs.speed_slow <= 7'd20;
      regs.speed_min  <= 7'd2;
      regs.gain_p     <= 12'd1485;
      regs.gain_d     <= 12'd768;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_FAST: regs.speed_fast <= cfg_data[6:0];
        CFG_SPEED_SLOW: regs.speed_slow <= cfg_data[6:0];
        CFG_SPEED_MIN:  regs.speed_min  <= cfg_data[6:0];
        CFG_GAIN_P:     regs.gain_p     <= cfg_data;
        CFG_GAIN_D:     regs.gain_d     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- hdl/lfsc_track.sv -----
// ----------------------------------------------------------------------------
// lfsc_track
// Input register, turn and beeper machines, line error and status decode.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_track import lfsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_sensors,
  output logic            in_ready,
  output logic            trk_valid,
  output trk_t            trk,
  input  wire logic       trk_ready
);

  typedef enum logic [2:0] {
    TURN_NONE  = 3'b001,
    TURN_LEFT  = 3'b010,
    TURN_RIGHT = 3'b100
  } turn_state_t;

  typedef enum logic [4:0] {
    BEEP_IDLE  = 5'b00001,
    BEEP_ENTRY = 5'b00010,
    BEEP_EXIT1 = 5'b00100,
    BEEP_GAP   = 5'b01000,
    BEEP_EXIT2 = 5'b10000
  } beep_phase_t;

  // input register
  logic       a_valid;
  logic [7:0] sensors;

  // frame state
  turn_state_t       turn_state, turn_state_next;
  logic [7:0]        turn_frames, turn_frames_next;
  logic              was_turning;
  beep_phase_t       beep_phase, beep_phase_next;
  logic [1:0]        beep_ticks, beep_ticks_next;
  logic              beep_level, beep_level_next;
  logic signed [4:0] last_good_error;
  logic              line_seen;
  logic signed [4:0] previous_error;

  // decode
  logic [2:0]        lcnt, rcnt;
  logic [3:0]        cnt;
  logic [8:0]        frame_inc;
  logic              turning;
  logic [2:0]        li, ri;
  logic signed [4:0] raw;
  logic [3:0]        raw_abs;
  logic signed [4:0] err;
  logic [3:0]        status;
  drive_t            drive;
  trk_t              trk_next;
  logic              b_ready;
  logic              advance;

  // handshake: each stage moves on when the next one has room
  assign b_ready  = !trk_valid || trk_ready;
  assign in_ready = !a_valid || b_ready;
  assign advance  = a_valid && b_ready;

  // lit sensors per side
  assign lcnt = {2'b0, sensors[0]} + {2'b0, sensors[1]} + {2'b0, sensors[2]}
              + {2'b0, sensors[3]};
  assign rcnt = {2'b0, sensors[4]} + {2'b0, sensors[5]} + {2'b0, sensors[6]}
              + {2'b0, sensors[7]};
  assign cnt  = {1'b0, lcnt} + {1'b0, rcnt};

  // right-angle turn machine
  always_comb begin
    turn_state_next  = turn_state;
    turn_frames_next = turn_frames;
    frame_inc        = '0;
    if (turn_state == TURN_NONE) begin
      if (lcnt >= 3'd3 && rcnt <= 3'd1) begin
        turn_state_next  = TURN_LEFT;
        turn_frames_next = '0;
      end else if (rcnt >= 3'd3 && lcnt <= 3'd1) begin
        turn_state_next  = TURN_RIGHT;
        turn_frames_next = '0;
      end
    end
    if (turn_state_next != TURN_NONE) begin
      frame_inc = {1'b0, turn_frames_next} + 9'd1;
      if (frame_inc > 9'(TURN_LIMIT)) begin
        turn_state_next = TURN_NONE;
        frame_inc       = '0;
      end else if (frame_inc <= 9'd3) begin
        // minimum turn length, no exit check
      end else if (turn_state_next == TURN_LEFT && sensors == 8'h01) begin
        turn_state_next = TURN_NONE;
        frame_inc       = '0;
      end else if (turn_state_next == TURN_RIGHT && sensors == 8'h80) begin
        turn_state_next = TURN_NONE;
        frame_inc       = '0;
      end
      turn_frames_next = frame_inc[7:0];
    end
  end

  assign turning = turn_state_next != TURN_NONE;

  // beeper: one beep on entry, two on exit
  always_comb begin
    beep_phase_next = beep_phase;
    beep_ticks_next = beep_ticks;
    beep_level_next = beep_level;
    if (turning && !was_turning) begin
      beep_phase_next = BEEP_ENTRY;
      beep_ticks_next = '0;
      beep_level_next = 1'b1;
    end
    if (!turning && was_turning) begin
      beep_phase_next = BEEP_EXIT1;
      beep_ticks_next = '0;
      beep_level_next = 1'b1;
    end
    if (beep_phase_next != BEEP_IDLE) begin
      beep_ticks_next = beep_ticks_next + 2'd1;
      case (beep_phase_next)
        BEEP_ENTRY: begin
          if (beep_ticks_next == 2'd3) begin
            beep_level_next = 1'b0;
            beep_phase_next = BEEP_IDLE;
          end
        end
        BEEP_EXIT1: begin
          if (beep_ticks_next >= 2'd2) begin
            beep_level_next = 1'b0;
            beep_phase_next = BEEP_GAP;
            beep_ticks_next = '0;
          end
        end
        BEEP_GAP: begin
          if (beep_ticks_next >= 2'd2) begin
            beep_level_next = 1'b1;
            beep_phase_next = BEEP_EXIT2;
            beep_ticks_next = '0;
          end
        end
        BEEP_EXIT2: begin
          if (beep_ticks_next >= 2'd2) begin
            beep_level_next = 1'b0;
            beep_phase_next = BEEP_IDLE;
          end
        end
        default: begin
          beep_phase_next = BEEP_IDLE;
          beep_ticks_next = '0;
          beep_level_next = 1'b0;
        end
      endcase
    end
  end

  // weighted line error, left minus right
  assign li      = {sensors[0], sensors[1], sensors[2]};
  assign ri      = {sensors[7], sensors[6], sensors[5]};
  assign raw     = $signed({1'b0, side_weight(li)}) - $signed({1'b0, side_weight(ri)});
  assign raw_abs = raw[4] ? 4'(-raw) : raw[3:0];
  assign err     = (cnt == 4'd0) ? last_good_error : raw;

  // drive kind and status
  always_comb begin
    drive = DRIVE_PD;
    if (turn_state_next == TURN_LEFT) begin
      drive  = DRIVE_LEFT;
      status = ST_TURN;
    end else if (turn_state_next == TURN_RIGHT) begin
      drive  = DRIVE_RIGHT;
      status = ST_TURN;
    end else if (cnt == 4'd0) begin
      if (line_seen) begin
        status = ST_LOST;
      end else begin
        drive  = DRIVE_SEARCH;
        status = ST_SEARCH;
      end
    end else if (cnt == 4'd8) begin
      status = ST_CROSS;
    end else if (raw_abs <= 4'd1) begin
      status = ST_GO;
    end else if (raw_abs <= 4'd3) begin
      status = raw[4] ? ST_LEFT1 : ST_RIGHT1;
    end else if (raw_abs <= 4'd7) begin
      status = raw[4] ? ST_LEFT2 : ST_RIGHT2;
    end else begin
      status = raw[4] ? ST_LEFT3 : ST_RIGHT3;
    end
  end

  // decoded frame
  always_comb begin
    trk_next.drive = drive;
    trk_next.err   = err;
    trk_next.diff  = 6'(err) - 6'(previous_error);
    trk_next.mag   = err[4] ? 4'(-err) : err[3:0];
    case (turn_state_next)
      TURN_LEFT:  trk_next.tail.turn_mode = MODE_LEFT;
      TURN_RIGHT: trk_next.tail.turn_mode = MODE_RIGHT;
      default:    trk_next.tail.turn_mode = MODE_NORMAL;
    endcase
    trk_next.tail.turn_count   = turn_frames_next;
    trk_next.tail.beeper_on    = beep_level_next;
    trk_next.tail.track_status = status;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      sensors <= in_sensors;
    end
  end

  // frame state and decoded output register
  always_ff @(posedge clk) begin
    if (rst) begin
      trk_valid       <= 1'b0;
      turn_state      <= TURN_NONE;
      turn_frames     <= '0;
      was_turning     <= 1'b0;
      beep_phase      <= BEEP_IDLE;
      beep_ticks      <= '0;
      beep_level      <= 1'b0;
      last_good_error <= '0;
      line_seen       <= 1'b0;
      previous_error  <= '0;
    end else begin
      if (b_ready) begin
        trk_valid <= a_valid;
      end
      if (advance) begin
        turn_state  <= turn_state_next;
        turn_frames <= turn_frames_next;
        was_turning <= turning;
        beep_phase  <= beep_phase_next;
        beep_ticks  <= beep_ticks_next;
        beep_level  <= beep_level_next;
        if (!turning && cnt != 4'd0) begin
          line_seen       <= 1'b1;
          last_good_error <= raw;
        end
        if (drive == DRIVE_PD) begin
          previous_error <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trk <= trk_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lfsc_steer.sv -----
// ----------------------------------------------------------------------------
// lfsc_steer
// PD steering datapath: gain products, clamp and curve slow-down, wheels.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_steer import lfsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       trk_valid,
  input  wire trk_t       trk,
  output logic            trk_ready,
  output logic            out_valid,
  output logic [7:0]      left_speed,
  output logic [7:0]      right_speed,
  output tail_t           out_tail,
  input  wire logic       out_ready
);

  // stage C: products
  logic              c_valid;
  drive_t            c_drive;
  tail_t             c_tail;
  logic signed [18:0] c_steer;
  logic [13:0]       c_base_prod;

  // stage D: clamp and divide
  logic              d_valid;
  drive_t            d_drive;
  tail_t             d_tail;
  logic signed [14:0] d_steer;
  logic [6:0]        d_base;

  logic c_ready, d_ready, e_ready;

  logic signed [17:0] gp_ext, gd_ext, prod_p, prod_d;
  logic [6:0]         curve;
  logic [23:0]        div_prod;
  logic [6:0]         base_m;
  logic signed [16:0] base_q8, v_left, v_right;
  logic [7:0]         w_left, w_right, left_next, right_next;

  // handshake
  assign e_ready   = !out_valid || out_ready;
  assign d_ready   = !d_valid || e_ready;
  assign c_ready   = !c_valid || d_ready;
  assign trk_ready = c_ready;

  // steering products and speed product
  assign gp_ext = $signed({6'b0, cfg.gain_p});
  assign gd_ext = $signed({6'b0, cfg.gain_d});
  assign prod_p = gp_ext * 18'(trk.err);
  assign prod_d = gd_ext * 18'(trk.diff);
  assign curve  = 7'd120 - 7'(7'd7 * {3'b0, trk.mag});

  always_ff @(posedge clk) begin
    if (c_ready && trk_valid) begin
      c_drive     <= trk.drive;
      c_tail      <= trk.tail;
      c_steer     <= 19'(prod_p) + 19'(prod_d);
      c_base_prod <= {7'b0, cfg.speed_fast} * {7'b0, curve};
    end
  end

  // clamp steer; base = floor(prod/120) = floor(floor(prod/8)/15)
  assign div_prod = {2'b0, c_base_prod[13:3]} * {11'b0, DIV15_RECIP};

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      d_drive <= c_drive;
      d_tail  <= c_tail;
      d_base  <= div_prod[22:16];
      if (c_steer > 19'(STEER_LIMIT_Q8)) begin
        d_steer <= 15'(STEER_LIMIT_Q8);
      end else if (c_steer < -19'(STEER_LIMIT_Q8)) begin
        d_steer <= -15'(STEER_LIMIT_Q8);
      end else begin
        d_steer <= c_steer[14:0];
      end
    end
  end

  // wheels: truncate toward zero, clamp to 0..speed_fast
  assign base_m  = (d_base < cfg.speed_min) ? cfg.speed_min : d_base;
  assign base_q8 = $signed({2'b0, base_m, 8'b0});
  assign v_left  = base_q8 - 17'(d_steer);
  assign v_right = base_q8 + 17'(d_steer);
  assign w_left  = v_left[16] ? 8'd0 : v_left[15:8];
  assign w_right = v_right[16] ? 8'd0 : v_right[15:8];

  always_comb begin
    case (d_drive)
      DRIVE_LEFT: begin
        left_next  = 8'd0;
        right_next = {1'b0, cfg.speed_slow};
      end
      DRIVE_RIGHT: begin
        left_next  = {1'b0, cfg.speed_slow};
        right_next = 8'd0;
      end
      DRIVE_SEARCH: begin
        left_next  = -{1'b0, cfg.speed_slow};
        right_next = {1'b0, cfg.speed_slow};
      end
      default: begin
        left_next  = (w_left > {1'b0, cfg.speed_fast}) ? {1'b0, cfg.speed_fast} : w_left;
        right_next = (w_right > {1'b0, cfg.speed_fast}) ? {1'b0, cfg.speed_fast}
                   : w_right;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (e_ready && d_valid) begin
      left_speed  <= left_next;
      right_speed <= right_next;
      out_tail    <= d_tail;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_ready) c_valid <= trk_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) out_valid <= d_valid;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/line_follow_steering_controller.sv -----
// ----------------------------------------------------------------------------
// line_follow_steering_controller
// Pipeline: a frame passes the input, decode, product and divide registers,
// then the output register, before m_tvalid rises.
// Throughput: one frame per cycle; each stage moves on when the next has room.
// Reset: empties the pipeline, clears turn, beeper and PD state and loads the
// default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_steering_controller import lfsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input frames
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sensors
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] left_speed, [15:8] right_speed,
                                      // [17:16] turn_mode, [25:18] turn_count,
                                      // [26] beeper_on, [30:27] track_status
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t       cfg;
  logic       trk_valid, trk_ready;
  trk_t       trk;
  logic [7:0] left_speed, right_speed;
  tail_t      tail;

  lfsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfsc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_sensors (s_tdata),
    .in_ready   (s_tready),
    .trk_valid  (trk_valid),
    .trk        (trk),
    .trk_ready  (trk_ready)
  );

  lfsc_steer u_steer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .trk_valid   (trk_valid),
    .trk         (trk),
    .trk_ready   (trk_ready),
    .out_valid   (m_tvalid),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .out_tail    (tail),
    .out_ready   (m_tready)
  );

  // result packing, first field lowest
  assign m_tdata = {1'b0, tail.track_status, tail.beeper_on, tail.turn_count,
                    tail.turn_mode, right_speed, left_speed};

endmodule

`default_nettype wire
